// ----- rtl/cscl_pkg.sv -----
// Shared types, constants and calendar helpers for the calendar seconds clock.
`default_nettype none

package cscl_pkg;

  // Item kinds carried in the kind field of an input beat.
  localparam logic [1:0] KIND_TICK = 2'd0;
  localparam logic [1:0] KIND_SET  = 2'd1;
  localparam logic [1:0] KIND_READ = 2'd2;

  // Calendar constants.
  localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
  localparam logic [11:0] SET_YEAR_MIN     = 12'd2000;
  localparam logic [11:0] SET_YEAR_MAX     = 12'd2099;
  localparam logic [11:0] NONLEAP_CENTURY  = 12'd2100;
  localparam logic [3:0]  MONTH_MAX        = 4'd12;
  localparam logic [3:0]  LAST_MONTH_IDX   = 4'd11;
  localparam logic [2:0]  EPOCH_WEEKDAY    = 3'd4;

  // Second counts.
  localparam logic [31:0] SECS_LEAP_YEAR = 32'd31622400;
  localparam logic [31:0] SECS_YEAR      = 32'd31536000;
  localparam logic [31:0] SECS_DAY       = 32'd86400;
  localparam logic [31:0] SECS_HOUR      = 32'd3600;
  localparam logic [31:0] SECS_MIN       = 32'd60;

  // Input beat.
  typedef struct packed {
    logic [1:0]  kind;
    logic [11:0] set_year;
    logic [3:0]  set_month;
    logic [4:0]  set_day;
    logic [4:0]  set_hour;
    logic [5:0]  set_minute;
    logic [5:0]  set_second;
  } cscl_in_t;

  // Result beat.
  typedef struct packed {
    logic        status;
    logic [31:0] seconds_total;
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [2:0]  weekday;
  } cscl_out_t;

  // Request to the shared add/subtract unit.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic        sub;
  } cscl_alu_req_t;

  // Status of the conversion engine toward the channel logic.
  typedef struct packed {
    logic ready;
    logic res_valid;
  } cscl_eng_stat_t;

  // Gregorian leap rule, exact for the years 1901 through 2199.
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'b00) && (y != NONLEAP_CENTURY);
  endfunction

  // Length of a year in seconds.
  function automatic logic [31:0] year_secs(input logic [11:0] y);
    return is_leap(y) ? SECS_LEAP_YEAR : SECS_YEAR;
  endfunction

  // Length in days of a zero-based month.
  function automatic logic [4:0] month_len(input logic [3:0] m0, input logic leap);
    logic [4:0] len;
    case (m0)
      4'd1:    len = leap ? 5'd29 : 5'd28;
      4'd3:    len = 5'd30;
      4'd5:    len = 5'd30;
      4'd8:    len = 5'd30;
      4'd10:   len = 5'd30;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

  // Length of a zero-based month in seconds.
  function automatic logic [31:0] month_secs(input logic [3:0] m0, input logic leap);
    return {27'd0, month_len(m0, leap)} * SECS_DAY;
  endfunction

  // Weekday shift caused by a month of the given length.
  function automatic logic [2:0] len_mod7(input logic [4:0] len);
    logic [2:0] r;
    case (len)
      5'd31:   r = 3'd3;
      5'd30:   r = 3'd2;
      5'd29:   r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

  // Weekday advance modulo seven; both operands are below seven.
  function automatic logic [2:0] wd_add(input logic [2:0] wd, input logic [2:0] k);
    logic [3:0] s;
    s = {1'b0, wd} + {1'b0, k};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cscl_alu.sv -----
// Shared 32-bit add/subtract unit with borrow output.
`default_nettype none

module cscl_alu (
  input  cscl_pkg::cscl_alu_req_t req,
  output logic [31:0]             y,
  output logic                    borrow
);
  import cscl_pkg::*;

  logic [32:0] wide;

  // One adder serves both directions; the top bit is the borrow of a subtract.
  always_comb begin
    if (req.sub) begin
      wide = {1'b0, req.a} - {1'b0, req.b};
    end else begin
      wide = {1'b0, req.a} + {1'b0, req.b};
    end
  end

  assign y      = wide[31:0];
  assign borrow = wide[32];

endmodule

`default_nettype wire

// ----- rtl/cscl_engine.sv -----
// Sequencer and counter that convert between seconds and calendar fields.
`default_nettype none

module cscl_engine (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      start,
  input  cscl_pkg::cscl_in_t       item,
  input  wire                      res_take,
  output cscl_pkg::cscl_eng_stat_t stat,
  output cscl_pkg::cscl_out_t      res
);
  import cscl_pkg::*;

  typedef enum logic [13:0] {
    S_IDLE     = 14'h0001,
    S_SET_YEAR = 14'h0002,
    S_SET_MON  = 14'h0004,
    S_SET_DAY  = 14'h0008,
    S_SET_ADJ  = 14'h0010,
    S_SET_HOUR = 14'h0020,
    S_SET_MIN  = 14'h0040,
    S_SET_SEC  = 14'h0080,
    S_DEC_YEAR = 14'h0100,
    S_DEC_MON  = 14'h0200,
    S_DEC_DAY  = 14'h0400,
    S_DEC_HOUR = 14'h0800,
    S_DEC_MIN  = 14'h1000,
    S_DONE     = 14'h2000
  } state_t;

  state_t        state_r, state_nxt;
  logic [31:0]   cnt_r, cnt_nxt;
  logic [31:0]   acc_r, acc_nxt;
  logic [11:0]   year_r, year_nxt;
  logic [3:0]    mon_r, mon_nxt;
  logic [4:0]    day_r, day_nxt;
  logic [4:0]    hour_r, hour_nxt;
  logic [5:0]    min_r, min_nxt;
  logic [2:0]    wd_r, wd_nxt;
  logic          status_r, status_nxt;
  cscl_in_t      item_r, item_nxt;

  cscl_alu_req_t alu_req;
  logic [31:0]   alu_y;
  logic          alu_borrow;
  logic          dec_init;
  logic [31:0]   dec_src;
  logic          leap;
  logic [4:0]    mlen;

  cscl_alu u_alu (
    .req    (alu_req),
    .y      (alu_y),
    .borrow (alu_borrow)
  );

  assign leap = is_leap(year_r);
  assign mlen = month_len(mon_r, leap);

  // Sequencer: every step drives the shared unit at most once.
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    acc_nxt    = acc_r;
    year_nxt   = year_r;
    mon_nxt    = mon_r;
    day_nxt    = day_r;
    hour_nxt   = hour_r;
    min_nxt    = min_r;
    wd_nxt     = wd_r;
    status_nxt = status_r;
    item_nxt   = item_r;
    alu_req.a   = acc_r;
    alu_req.b   = 32'd0;
    alu_req.sub = 1'b0;
    dec_init   = 1'b0;
    dec_src    = cnt_r;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          item_nxt   = item;
          status_nxt = 1'b0;
          case (item.kind)
            KIND_TICK: begin
              alu_req.a = cnt_r;
              alu_req.b = 32'd1;
              cnt_nxt   = alu_y;
            end
            KIND_SET: begin
              if ((item.set_year < SET_YEAR_MIN) || (item.set_year > SET_YEAR_MAX) ||
                  (item.set_month == 4'd0) || (item.set_month > MONTH_MAX)) begin
                // Rejected set: report the unchanged counter.
                status_nxt = 1'b1;
                dec_init   = 1'b1;
              end else begin
                acc_nxt   = 32'd0;
                year_nxt  = EPOCH_YEAR;
                mon_nxt   = 4'd0;
                state_nxt = S_SET_YEAR;
              end
            end
            KIND_READ: begin
              dec_init = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end

      // Sum whole years from the epoch up to the target year.
      S_SET_YEAR: begin
        if (year_r < item_r.set_year) begin
          alu_req.b = year_secs(year_r);
          acc_nxt   = alu_y;
          year_nxt  = year_r + 12'd1;
        end else begin
          state_nxt = S_SET_MON;
        end
      end

      // Sum whole months before the target month.
      S_SET_MON: begin
        if (({1'b0, mon_r} + 5'd1) < {1'b0, item_r.set_month}) begin
          alu_req.b = month_secs(mon_r, leap);
          acc_nxt   = alu_y;
          mon_nxt   = mon_r + 4'd1;
        end else begin
          state_nxt = S_SET_DAY;
        end
      end

      // Day, hour, minute and second are added linearly and wrap.
      S_SET_DAY: begin
        alu_req.b = {27'd0, item_r.set_day} * SECS_DAY;
        acc_nxt   = alu_y;
        state_nxt = S_SET_ADJ;
      end
      S_SET_ADJ: begin
        alu_req.b   = SECS_DAY;
        alu_req.sub = 1'b1;
        acc_nxt     = alu_y;
        state_nxt   = S_SET_HOUR;
      end
      S_SET_HOUR: begin
        alu_req.b = {27'd0, item_r.set_hour} * SECS_HOUR;
        acc_nxt   = alu_y;
        state_nxt = S_SET_MIN;
      end
      S_SET_MIN: begin
        alu_req.b = {26'd0, item_r.set_minute} * SECS_MIN;
        acc_nxt   = alu_y;
        state_nxt = S_SET_SEC;
      end
      S_SET_SEC: begin
        alu_req.b = {26'd0, item_r.set_second};
        cnt_nxt   = alu_y;
        dec_init  = 1'b1;
        dec_src   = alu_y;
      end

      // Peel off whole years while the remainder covers one.
      S_DEC_YEAR: begin
        alu_req.b   = year_secs(year_r);
        alu_req.sub = 1'b1;
        if (!alu_borrow) begin
          acc_nxt  = alu_y;
          year_nxt = year_r + 12'd1;
          wd_nxt   = wd_add(wd_r, leap ? 3'd2 : 3'd1);
        end else begin
          state_nxt = S_DEC_MON;
        end
      end

      // Peel off whole months; December takes what is left.
      S_DEC_MON: begin
        alu_req.b   = month_secs(mon_r, leap);
        alu_req.sub = 1'b1;
        if ((mon_r < LAST_MONTH_IDX) && !alu_borrow) begin
          acc_nxt = alu_y;
          mon_nxt = mon_r + 4'd1;
          wd_nxt  = wd_add(wd_r, len_mod7(mlen));
        end else begin
          state_nxt = S_DEC_DAY;
        end
      end

      // Peel off whole days.
      S_DEC_DAY: begin
        alu_req.b   = SECS_DAY;
        alu_req.sub = 1'b1;
        if (!alu_borrow) begin
          acc_nxt = alu_y;
          day_nxt = day_r + 5'd1;
          wd_nxt  = wd_add(wd_r, 3'd1);
        end else begin
          state_nxt = S_DEC_HOUR;
        end
      end

      // Peel off whole hours.
      S_DEC_HOUR: begin
        alu_req.b   = SECS_HOUR;
        alu_req.sub = 1'b1;
        if (!alu_borrow) begin
          acc_nxt  = alu_y;
          hour_nxt = hour_r + 5'd1;
        end else begin
          state_nxt = S_DEC_MIN;
        end
      end

      // Peel off whole minutes; the rest is the second.
      S_DEC_MIN: begin
        alu_req.b   = SECS_MIN;
        alu_req.sub = 1'b1;
        if (!alu_borrow) begin
          acc_nxt = alu_y;
          min_nxt = min_r + 6'd1;
        end else begin
          state_nxt = S_DONE;
        end
      end

      // Hold the result until the output register takes it.
      S_DONE: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // Start a decode of the counter value after the item.
    if (dec_init) begin
      acc_nxt   = dec_src;
      year_nxt  = EPOCH_YEAR;
      mon_nxt   = 4'd0;
      day_nxt   = 5'd0;
      hour_nxt  = 5'd0;
      min_nxt   = 6'd0;
      wd_nxt    = EPOCH_WEEKDAY;
      state_nxt = S_DEC_YEAR;
    end
  end

  // Control state and the counter are reset; the working registers are not.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= 32'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    year_r   <= year_nxt;
    mon_r    <= mon_nxt;
    day_r    <= day_nxt;
    hour_r   <= hour_nxt;
    min_r    <= min_nxt;
    wd_r     <= wd_nxt;
    status_r <= status_nxt;
    item_r   <= item_nxt;
  end

  // Status and result toward the channel logic.
  assign stat.ready     = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);

  assign res.status        = status_r;
  assign res.seconds_total = cnt_r;
  assign res.year          = year_r;
  assign res.month         = mon_r + 4'd1;
  assign res.day           = day_r + 5'd1;
  assign res.hour          = hour_r;
  assign res.minute        = min_r;
  assign res.second        = acc_r[5:0];
  assign res.weekday       = wd_r;

endmodule

`default_nettype wire

// ----- rtl/calendar_seconds_clock_top.sv -----
// Top level of the calendar seconds clock: channel handshakes and result register.
//
// The block keeps a 32-bit count of seconds since 1970-01-01 00:00:00.
// Input beats arrive on in_valid/in_stall/in_data; a beat is taken at a
// rising edge with in_valid high and in_stall low. A tick beat adds one
// second and produces no result. A set beat loads the counter from
// calendar fields and a read beat decodes it; both produce one result
// beat on out_valid/out_stall/out_data with status, counter, date, time
// and weekday.
// One shared 32-bit add/subtract unit walks years, months, days, hours and
// minutes one step per cycle, and the next item is taken in the cycle
// after the result is handed over. in_stall stays high while an item is
// in the engine. The result sits in an output register, so the next item
// is taken while a result waits on a stalled receiver; the engine then
// holds its own result until that register frees up.
// Reset clears the counter to zero and empties the engine and the output.
`default_nettype none

module calendar_seconds_clock_top (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  cscl_pkg::cscl_in_t  in_data,
  output logic                out_valid,
  input  wire                 out_stall,
  output cscl_pkg::cscl_out_t out_data
);
  import cscl_pkg::*;

  cscl_eng_stat_t eng_stat;
  cscl_out_t      eng_res;
  logic           out_valid_r, out_valid_nxt;
  cscl_out_t      out_data_r;
  logic           out_take;
  logic           in_fire;

  // The output register can load when empty or being drained this cycle.
  assign out_take = !out_valid_r || !out_stall;
  assign in_stall = !eng_stat.ready;
  assign in_fire  = in_valid && eng_stat.ready;

  cscl_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_fire),
    .item     (in_data),
    .res_take (out_take),
    .stat     (eng_stat),
    .res      (eng_res)
  );

  // Output beat valid tracking.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (eng_stat.res_valid && out_take) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload loads only with a new beat, so a stalled beat holds.
  always_ff @(posedge clk) begin
    if (eng_stat.res_valid && out_take) begin
      out_data_r <= eng_res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
